[rtl/modular_arithmetic_unit_defines.svh]
`ifndef MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define MAU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MAU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mau_pkg.sv]
package mau_pkg;

  localparam int RW = 30;
  localparam int WW = 64;

  typedef logic [RW-1:0] residue_t;
  typedef logic signed [WW-1:0] wide_t;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_POW = 3'd4,
    KIND_INV = 3'd5,
    KIND_NEG = 3'd6,
    KIND_RED = 3'd7
  } kind_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_POW  = 6'b000100,
    ST_EUC  = 6'b001000,
    ST_RED  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  localparam residue_t MOD_RESET = 30'd1000000007;

endpackage

[rtl/mau_if.sv]
interface mau_in_if;
  import mau_pkg::*;
  logic     valid;
  logic     ready;
  kind_t    kind;
  residue_t lhs;
  residue_t rhs;
  wide_t    wide_value;
  modport source (output valid, kind, lhs, rhs, wide_value, input ready);
  modport sink (input valid, kind, lhs, rhs, wide_value, output ready);
endinterface

interface mau_out_if;
  import mau_pkg::*;
  logic     valid;
  logic     ready;
  residue_t result;
  logic     operand_error;
  modport source (output valid, result, operand_error, input ready);
  modport sink (input valid, result, operand_error, output ready);
endinterface

interface mau_cfg_if;
  import mau_pkg::*;
  logic     valid;
  logic     ready;
  residue_t modulus;
  modport source (output valid, modulus, input ready);
  modport sink (input valid, modulus, output ready);
endinterface

[rtl/modular_arithmetic_unit.sv]
// Modular arithmetic unit.
// in_ch: one word per operation (kind, lhs, rhs, wide_value), valid/ready.
// out_ch: one word per accepted input (result, operand_error), valid/ready.
// cfg_ch: modulus write, always ready; write only while the unit is idle.
// One operation is in flight at a time; in_ch.ready is high in idle only.
// A new word is taken only once the previous one has left its done state.
// Path from accept to out_ch.valid, through a bit-serial datapath
// (one operand bit per cycle):
//   add, sub, negate, operand errors: result formed at accept, then done
//   mul: one pass over the rhs bits; reduce: one pass over 64 magnitude bits
//   inverse: one bit-serial division pass per Euclid step, then done
//   div: inverse, then multiply by lhs; pow: up to 126 multiplies
// The next word is accepted as soon as the previous result sits in the
// output register; a stalled out_ch holds the result and the following
// operation waits in its done state until the register frees up.
// Reset returns to idle, clears out_ch.valid and sets modulus 1000000007.
`include "modular_arithmetic_unit_defines.svh"
module modular_arithmetic_unit (
  input logic clk,
  input logic rst_n,
  mau_in_if.sink   in_ch,
  mau_out_if.source out_ch,
  mau_cfg_if.sink  cfg_ch
);
  import mau_pkg::*;

  state_t   state_r, state_nxt;
  kind_t    kind_r, kind_nxt;
  residue_t mod_r;
  residue_t lhs_r, lhs_nxt;
  residue_t acc_r, acc_nxt;
  residue_t ma_r, ma_nxt;
  residue_t mb_r, mb_nxt;
  residue_t pacc_r, pacc_nxt;
  residue_t psq_r, psq_nxt;
  logic [WW-1:0] pe_r, pe_nxt;
  logic     phase_r, phase_nxt;
  logic     neg_r, neg_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  residue_t ea_r, ea_nxt;
  residue_t eb_r, eb_nxt;
  residue_t rem_r, rem_nxt;
  logic signed [31:0] eu_r, eu_nxt;
  logic signed [31:0] ev_r, ev_nxt;
  logic signed [32:0] prod_r, prod_nxt;
  residue_t res_r, res_nxt;
  logic     err_r, err_nxt;
  logic     ov_r, ov_nxt;
  residue_t ores_r, ores_nxt;
  logic     oerr_r, oerr_nxt;

  logic [RW:0] m_ext, mt1, mt2, rt, add_s, sub_s, remsh, rem_sub;
  logic        in_err, q_bit;
  residue_t    rem_new, inv_val, red_fin;
  logic signed [32:0] prod_new, v_new;
  logic [31:0] u_mag;
  logic [WW-1:0] wmag;

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = ov_r;
  assign out_ch.result       = ores_r;
  assign out_ch.operand_error = oerr_r;

  always_comb begin
    m_ext = {1'b0, mod_r};
    // shift-add multiply step
    mt1 = {acc_r, 1'b0};
    if (mt1 >= m_ext) begin
      mt1 = mt1 - m_ext;
    end
    mt2 = mt1 + (mb_r[cnt_r[4:0]] ? {1'b0, ma_r} : '0);
    if (mt2 >= m_ext) begin
      mt2 = mt2 - m_ext;
    end
    // reduce step
    rt = {acc_r, pe_r[cnt_r]};
    if (rt >= m_ext) begin
      rt = rt - m_ext;
    end
    red_fin = (neg_r && rt[RW-1:0] != '0) ? mod_r - rt[RW-1:0] : rt[RW-1:0];
    // Euclid division step
    remsh   = {rem_r, ea_r[cnt_r[4:0]]};
    rem_sub = remsh - {1'b0, eb_r};
    q_bit   = (remsh >= {1'b0, eb_r});
    rem_new = q_bit ? rem_sub[RW-1:0] : remsh[RW-1:0];
    prod_new = (prod_r <<< 1) + (q_bit ? {ev_r[31], ev_r} : 33'sd0);
    v_new    = {eu_r[31], eu_r} - prod_new;
    // fold final coefficient (held in ev_r) into 0..m-1
    u_mag = ev_r[31] ? 32'(-ev_r) : ev_r;
    if (ev_r[31]) begin
      inv_val = (u_mag == 32'd0 || u_mag == {2'b00, mod_r}) ? '0 :
                mod_r - u_mag[RW-1:0];
    end else begin
      inv_val = (u_mag >= {2'b00, mod_r}) ? u_mag[RW-1:0] - mod_r : u_mag[RW-1:0];
    end
    // direct ops
    add_s = {1'b0, in_ch.lhs} + {1'b0, in_ch.rhs};
    if (add_s >= m_ext) begin
      add_s = add_s - m_ext;
    end
    sub_s = {1'b0, in_ch.lhs} + (m_ext - {1'b0, in_ch.rhs});
    if (sub_s >= m_ext) begin
      sub_s = sub_s - m_ext;
    end
    wmag = in_ch.wide_value[WW-1] ? WW'(-in_ch.wide_value) : in_ch.wide_value;
    case (in_ch.kind)
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV:
        in_err = (in_ch.lhs >= mod_r) || (in_ch.rhs >= mod_r);
      KIND_INV, KIND_NEG: in_err = (in_ch.lhs >= mod_r);
      KIND_POW: in_err = (in_ch.lhs >= mod_r) || in_ch.wide_value[WW-1];
      default: in_err = 1'b0;
    endcase
    if (mod_r == '0) begin
      in_err = 1'b1;
    end

    state_nxt = state_r;
    kind_nxt  = kind_r;
    lhs_nxt   = lhs_r;
    acc_nxt   = acc_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    pacc_nxt  = pacc_r;
    psq_nxt   = psq_r;
    pe_nxt    = pe_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    ea_nxt    = ea_r;
    eb_nxt    = eb_r;
    rem_nxt   = rem_r;
    eu_nxt    = eu_r;
    ev_nxt    = ev_r;
    prod_nxt  = prod_r;
    res_nxt   = res_r;
    err_nxt   = err_r;
    ov_nxt    = ov_r && !out_ch.ready;
    ores_nxt  = ores_r;
    oerr_nxt  = oerr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt = in_ch.kind;
          lhs_nxt  = in_ch.lhs;
          err_nxt  = in_err;
          res_nxt  = '0;
          acc_nxt  = '0;
          cnt_nxt  = 6'd29;
          rem_nxt  = '0;
          prod_nxt = '0;
          eb_nxt   = mod_r;
          eu_nxt   = 32'sd1;
          ev_nxt   = 32'sd0;
          state_nxt = ST_DONE;
          if (!in_err) begin
            case (in_ch.kind)
              KIND_ADD: res_nxt = add_s[RW-1:0];
              KIND_SUB: res_nxt = sub_s[RW-1:0];
              KIND_NEG: res_nxt = (in_ch.lhs == '0) ? '0 : mod_r - in_ch.lhs;
              KIND_MUL: begin
                ma_nxt = in_ch.lhs;
                mb_nxt = in_ch.rhs;
                state_nxt = ST_MUL;
              end
              KIND_DIV: begin
                ea_nxt = in_ch.rhs;
                state_nxt = ST_EUC;
              end
              KIND_INV: begin
                ea_nxt = in_ch.lhs;
                state_nxt = ST_EUC;
              end
              KIND_POW: begin
                pacc_nxt  = (mod_r == RW'(1)) ? '0 : RW'(1);
                psq_nxt   = in_ch.lhs;
                pe_nxt    = in_ch.wide_value;
                phase_nxt = 1'b0;
                state_nxt = ST_POW;
              end
              default: begin
                pe_nxt  = wmag;
                neg_nxt = in_ch.wide_value[WW-1];
                cnt_nxt = 6'd63;
                state_nxt = ST_RED;
              end
            endcase
          end
        end
      end
      ST_MUL: begin
        acc_nxt = mt2[RW-1:0];
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          if (kind_r == KIND_POW) begin
            if (!phase_r) begin
              pacc_nxt  = mt2[RW-1:0];
              phase_nxt = 1'b1;
            end else begin
              psq_nxt   = mt2[RW-1:0];
              pe_nxt    = pe_r >> 1;
              phase_nxt = 1'b0;
            end
            state_nxt = ST_POW;
          end else begin
            res_nxt   = mt2[RW-1:0];
            state_nxt = ST_DONE;
          end
        end
      end
      ST_POW: begin
        acc_nxt = '0;
        cnt_nxt = 6'd29;
        if (!phase_r) begin
          if (pe_r == '0) begin
            res_nxt   = pacc_r;
            state_nxt = ST_DONE;
          end else if (pe_r[0]) begin
            ma_nxt    = pacc_r;
            mb_nxt    = psq_r;
            state_nxt = ST_MUL;
          end else begin
            phase_nxt = 1'b1;
          end
        end else begin
          ma_nxt    = psq_r;
          mb_nxt    = psq_r;
          state_nxt = ST_MUL;
        end
      end
      ST_EUC: begin
        rem_nxt  = rem_new;
        prod_nxt = prod_new;
        cnt_nxt  = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          ea_nxt   = eb_r;
          eb_nxt   = rem_new;
          eu_nxt   = ev_r;
          ev_nxt   = v_new[31:0];
          rem_nxt  = '0;
          prod_nxt = '0;
          cnt_nxt  = 6'd29;
          if (rem_new == '0) begin
            if (kind_r == KIND_DIV) begin
              acc_nxt   = '0;
              ma_nxt    = lhs_r;
              mb_nxt    = inv_val;
              state_nxt = ST_MUL;
            end else begin
              res_nxt   = inv_val;
              state_nxt = ST_DONE;
            end
          end
        end
      end
      ST_RED: begin
        acc_nxt = rt[RW-1:0];
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          res_nxt   = red_fin;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          ores_nxt  = res_r;
          oerr_nxt  = err_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      mod_r   <= MOD_RESET;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_ch.valid) begin
        mod_r <= cfg_ch.modulus;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    lhs_r   <= lhs_nxt;
    acc_r   <= acc_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    pacc_r  <= pacc_nxt;
    psq_r   <= psq_nxt;
    pe_r    <= pe_nxt;
    phase_r <= phase_nxt;
    neg_r   <= neg_nxt;
    cnt_r   <= cnt_nxt;
    ea_r    <= ea_nxt;
    eb_r    <= eb_nxt;
    rem_r   <= rem_nxt;
    eu_r    <= eu_nxt;
    ev_r    <= ev_nxt;
    prod_r  <= prod_nxt;
    res_r   <= res_nxt;
    err_r   <= err_nxt;
    ores_r  <= ores_nxt;
    oerr_r  <= oerr_nxt;
  end

  `MAU_ASSERT_NOW(a_err_zero, ov_r && oerr_r, ores_r == '0, "error word with nonzero result")
  `MAU_ASSERT_NOW(a_res_range, ov_r && !oerr_r, ores_r < mod_r, "result not reduced")
  `MAU_ASSERT_NXT(a_busy, in_ch.valid && in_ch.ready, state_r != ST_IDLE, "accept left idle")

endmodule
